/* sv/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace core.
// No dependencies; used by sfr_front, sfr_queue, sfr_back and the top level.
package sfr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 4;

    // Result slots one command can carry (one byte each).
    localparam int CMD_SLOTS   = 8;
    localparam int CNT_W       = $clog2(CMD_SLOTS + 1);
    localparam int POS_W       = $clog2(CMD_SLOTS);

    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACE_EVERY      = 3'd4;

    // Emission command: count bytes from the low end of bytes; a command
    // with count zero and last set is a bare end marker.
    typedef struct packed {
        logic [8*CMD_SLOTS-1:0] bytes;
        logic [CNT_W-1:0]       count;
        logic                   last;
    } t_cmd;

endpackage

/* sv/sfr_front.sv */
// Front end: configuration registers, match window and command builder.
// Depends on sfr_pkg.
module sfr_front #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [7:0]                         i_text_byte,
    input  logic                               i_end_of_text,
    input  logic                               i_q_full,
    output logic                               o_push,
    output sfr_pkg::t_cmd                      o_cmd
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W  = sfr_pkg::LEN_W;
    localparam int CNT_W  = sfr_pkg::CNT_W;
    localparam int SLOTS  = sfr_pkg::CMD_SLOTS;

    logic [63:0]       r_pat;
    logic [LEN_W-1:0]  r_plen;
    logic [63:0]       r_rep;
    logic [LEN_W-1:0]  r_rlen;
    logic              r_every;

    logic [7:0]        r_win [MAX_PATTERN];
    logic [7:0]        n_win [MAX_PATTERN];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_first_done;
    logic              n_first_done;

    logic [LEN_W-1:0]  plen_clamp;
    logic [LEN_W-1:0]  plen_use;
    logic [LEN_W-1:0]  rlen_use;
    logic [FILL_W-1:0] fill_app;
    logic [7:0]        w_app [SLOTS];
    logic              all_eq;
    logic              match;
    logic              pop;
    logic              accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        plen_clamp = (r_plen > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_plen;
        plen_use   = (!r_every && r_first_done) ? '0 : plen_clamp;
        rlen_use   = (r_rlen > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : r_rlen;
        fill_app   = r_fill + FILL_W'(1);

        // window with the new byte appended at the fill position
        for (int i = 0; i < SLOTS; i++) begin
            w_app[i] = 8'h00;
        end
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_app[i] = (FILL_W'(i) == r_fill) ? i_text_byte : r_win[i];
        end

        all_eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LEN_W'(i) < plen_use) && (w_app[i] != r_pat[8*i +: 8])) begin
                all_eq = 1'b0;
            end
        end
        match = (plen_use != '0) && (LEN_W'(fill_app) == plen_use) && all_eq;
        pop   = !match && (LEN_W'(fill_app) >= plen_use);

        o_cmd.last = i_end_of_text;
        if (match) begin
            o_cmd.bytes = r_rep;
            o_cmd.count = CNT_W'(rlen_use);
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                o_cmd.bytes[8*i +: 8] = w_app[i];
            end
            if (i_end_of_text) begin
                o_cmd.count = CNT_W'(fill_app);
            end else if (pop) begin
                o_cmd.count = CNT_W'(1);
            end else begin
                o_cmd.count = '0;
            end
        end
        o_push = accept && ((o_cmd.count != '0) || i_end_of_text);

        // window update
        for (int i = 0; i < MAX_PATTERN; i++) begin
            n_win[i] = w_app[i];
        end
        n_fill = fill_app;
        if (match || i_end_of_text) begin
            n_fill = '0;
        end else if (pop) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                n_win[i] = w_app[i+1];
            end
            n_fill = r_fill;
        end

        if (i_end_of_text) begin
            n_first_done = 1'b0;
        end else if (match && !r_every) begin
            n_first_done = 1'b1;
        end else begin
            n_first_done = r_first_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat        <= '0;
            r_plen       <= '0;
            r_rep        <= '0;
            r_rlen       <= '0;
            r_every      <= 1'b1;
            r_fill       <= '0;
            r_first_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sfr_pkg::REG_PATTERN_BYTES:      r_pat   <= i_cfg_data;
                    sfr_pkg::REG_PATTERN_LENGTH:     r_plen  <= i_cfg_data[LEN_W-1:0];
                    sfr_pkg::REG_REPLACEMENT_BYTES:  r_rep   <= i_cfg_data;
                    sfr_pkg::REG_REPLACEMENT_LENGTH: r_rlen  <= i_cfg_data[LEN_W-1:0];
                    sfr_pkg::REG_REPLACE_EVERY:      r_every <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_fill       <= n_fill;
                r_first_done <= n_first_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) < MAX_PATTERN)
        else $error("window fill reached pattern capacity between items");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_of_text |=> r_fill == '0 && !r_first_done)
        else $error("end of text did not clear window state");

endmodule

/* sv/sfr_queue.sv */
// Small command FIFO between front and back end.
// Depends on sfr_pkg (t_cmd, QUEUE_DEPTH).
module sfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfr_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output sfr_pkg::t_cmd o_head,
    input  logic          i_pop
);

    localparam int DEPTH = sfr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("command queue overflow or underflow");

endmodule

/* sv/sfr_back.sv */
// Back end: expands commands, one result per unstalled cycle.
// Depends on sfr_pkg (t_cmd, slot widths).
module sfr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  sfr_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_present,
    output logic          o_last_of_text
);

    localparam int POS_W = sfr_pkg::POS_W;
    localparam int CNT_W = sfr_pkg::CNT_W;

    logic [POS_W-1:0] r_pos;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_present;
    logic             r_last;

    logic             load;
    logic             empty_cmd;
    logic             cmd_done;

    assign empty_cmd = (i_head.count == '0);
    assign cmd_done  = empty_cmd || (CNT_W'(r_pos) + CNT_W'(1) == i_head.count);
    assign load      = i_q_valid && (!r_valid || i_ready);
    assign o_pop     = load && cmd_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos   <= cmd_done ? '0 : r_pos + POS_W'(1);
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= empty_cmd ? 8'h00 : i_head.bytes[{r_pos, 3'b000} +: 8];
            r_present <= !empty_cmd;
            r_last    <= i_head.last && cmd_done;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_byte_present = r_present;
    assign o_last_of_text = r_last;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_pos == '0) || (CNT_W'(r_pos) < i_head.count))
        else $error("slot position ran past command length");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_present |-> r_last && (r_byte == 8'h00))
        else $error("byteless result is not a clean end marker");

endmodule

/* sv/stream_find_and_replace_core.sv */
// Top level of the streaming find-and-replace core.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one text byte per transfer, with
//   i_end_of_text on the last byte. Output channel (o_valid/i_ready) gives
//   one rewritten byte per transfer; o_last_of_text marks the final one,
//   and a text whose tail produces nothing ends with a byteless marker
//   (o_byte_present low, o_out_byte zero).
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (pattern bytes, pattern length, replacement bytes, replacement length,
//   replace-every). Write only while no text is in flight.
//   Result path: the first result of an input transfer is written into the
//   command queue, then loaded into the output register when the back end is free.
//   Throughput: one input byte per cycle while the queue has room; the back
//   end sends one result per cycle while the receiver is ready, so a match
//   (up to MAX_REPLACEMENT results) or an end flush (up to MAX_PATTERN
//   results) occupies it until all its results are sent. The four-entry
//   command queue absorbs such bursts; o_ready drops only when it is full.
//   Reset: synchronous, clears window, queue and output valid; registers
//   return to defaults (replace-every set, lengths zero).
//   Receiver stall: the output register holds; the queue fills, then the
//   input side stalls. Nothing is dropped.
module stream_find_and_replace_core #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_end_of_text,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_present,
    output logic                            o_last_of_text
);

    // front to queue
    logic          push;
    sfr_pkg::t_cmd push_cmd;
    logic          q_full;
    // queue to back
    logic          q_valid;
    sfr_pkg::t_cmd q_head;
    logic          q_pop;

    // Front: window shift/compare per transfer, emits one command per item
    // that produces results or ends the text.
    sfr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // Decouples the front from output stalls and multi-byte bursts.
    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // Back: serializes each command into results through the output register.
    sfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_last_of_text (o_last_of_text)
    );

endmodule
